@@ rtl/core/sxfb_pkg.sv @@
package sxfb_pkg;

	localparam int ROW_BITS = 64;

	typedef enum logic [1:0] {
		REQ_DRAW  = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_READ  = 2'd2,
		REQ_ACK   = 2'd3
	} req_t;

	typedef struct packed {
		logic collision;
		logic redraw;
	} flags_t;

endpackage

@@ rtl/core/sxfb_ram.sv @@
module sxfb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/sxfb_index.sv @@
module sxfb_index #(
	parameter int DISPLAY_WIDTH  = 64,
	parameter int DISPLAY_HEIGHT = 32
) (
	input  logic [7:0]                        x_pos,
	input  logic [7:0]                        y_pos,
	input  logic [3:0]                        row_offset,
	output logic [$clog2(DISPLAY_HEIGHT)-1:0] row,
	output logic [$clog2(DISPLAY_WIDTH)-1:0]  col
);

	localparam int AW = $clog2(DISPLAY_HEIGHT);
	localparam int CW = $clog2(DISPLAY_WIDTH);

	typedef logic [AW-1:0] ylut_t [256];
	typedef logic [CW-1:0] xlut_t [256];

	function automatic ylut_t build_ylut();
		ylut_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = AW'(i % DISPLAY_HEIGHT);
		end
		return t;
	endfunction

	function automatic xlut_t build_xlut();
		xlut_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = CW'(i % DISPLAY_WIDTH);
		end
		return t;
	endfunction

	localparam ylut_t YLUT = build_ylut();
	localparam xlut_t XLUT = build_xlut();

	logic [AW-1:0] ymod;
	logic [7:0]    omod;
	logic [AW:0]   sum;

	always_comb begin
		ymod = YLUT[y_pos];
		col  = XLUT[x_pos];
		if (8'(row_offset) >= 8'(DISPLAY_HEIGHT)) begin
			omod = 8'(row_offset) - 8'(DISPLAY_HEIGHT);
		end else begin
			omod = 8'(row_offset);
		end
		sum = {1'b0, ymod} + {1'b0, AW'(omod)};
		if (sum >= (AW+1)'(DISPLAY_HEIGHT)) begin
			row = AW'(sum - (AW+1)'(DISPLAY_HEIGHT));
		end else begin
			row = AW'(sum);
		end
	end

endmodule

@@ rtl/core/sxfb_update.sv @@
module sxfb_update #(
	parameter int DISPLAY_WIDTH = 64
) (
	input  sxfb_pkg::req_t                   req,
	input  logic [DISPLAY_WIDTH-1:0]         old_row,
	input  logic [$clog2(DISPLAY_WIDTH)-1:0] col,
	input  logic [7:0]                       row_bits,
	input  logic                             off_zero,
	input  sxfb_pkg::flags_t                 flags_in,
	output logic [DISPLAY_WIDTH-1:0]         new_row,
	output sxfb_pkg::flags_t                 flags_out
);

	import sxfb_pkg::*;

	localparam int CW = $clog2(DISPLAY_WIDTH);

	logic [DISPLAY_WIDTH-1:0] mask;
	logic [CW:0]              c [8];
	logic                     hit;

	always_comb begin
		mask = '0;
		for (int b = 0; b < 8; b++) begin
			c[b] = (CW+1)'(col) + (CW+1)'(b);
			if (c[b] >= (CW+1)'(DISPLAY_WIDTH)) begin
				c[b] = c[b] - (CW+1)'(DISPLAY_WIDTH);
			end
			if (row_bits[7-b]) begin
				mask[CW'(c[b])] = 1'b1;
			end
		end
		hit     = |(old_row & mask);
		new_row = old_row ^ mask;

		flags_out = flags_in;
		case (req)
			REQ_DRAW: begin
				flags_out.collision = (flags_in.collision & ~off_zero) | hit;
				flags_out.redraw    = flags_in.redraw | (|mask);
			end
			REQ_CLEAR: begin
				flags_out.redraw = 1'b1;
			end
			REQ_ACK: begin
				flags_out.redraw = 1'b0;
			end
			default: begin
				flags_out = flags_in;
			end
		endcase
	end

endmodule

@@ rtl/core/sprite_xor_framebuffer.sv @@
// One-bit framebuffer, DISPLAY_HEIGHT rows by DISPLAY_WIDTH columns, with wrapping XOR
// sprite rows, clear, row read and redraw acknowledge. Every item gives exactly one result,
// which passes through the s1 stage register and then sits in an output register until
// taken. One item is accepted per cycle while the output side keeps up: each item makes
// one read of the row RAM (registered read) and at most one write-back as it leaves s1,
// with the row written on the accept edge forwarded to the following item. Per-row valid
// flops make reset and clear take effect at once, so there is no clearing pass.
module sprite_xor_framebuffer #(
	parameter int DISPLAY_WIDTH  = 64,
	parameter int DISPLAY_HEIGHT = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [7:0]                    x_pos,
	input  logic [7:0]                    y_pos,
	input  logic [3:0]                    row_offset,
	input  logic [7:0]                    row_bits,
	input  logic [4:0]                    read_row,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          collision,
	output logic                          redraw_needed,
	output logic [sxfb_pkg::ROW_BITS-1:0] row_data
);

	import sxfb_pkg::*;

	localparam int AW = $clog2(DISPLAY_HEIGHT);
	localparam int CW = $clog2(DISPLAY_WIDTH);

	logic                     in_fire, s1_fire, out_free;
	req_t                     req_in;
	logic [AW-1:0]            draw_row_idx, rd_addr;
	logic [CW-1:0]            col_in;

	logic                     s1_valid_q;
	req_t                     req_s1;
	logic [AW-1:0]            addr_s1;
	logic [CW-1:0]            col_s1;
	logic [7:0]               bits_s1;
	logic                     off_zero_s1;
	logic                     rd_ok_s1;
	logic                     fwd_hit_s1;
	logic [DISPLAY_WIDTH-1:0] fwd_data_s1;

	logic [DISPLAY_HEIGHT-1:0] row_valid_q;
	flags_t                    flags_q, flags_nx;
	logic                      out_valid_q;

	logic [DISPLAY_WIDTH-1:0] ram_rdata, old_row, new_row;
	logic                     wr_en;

	assign req_in   = req_t'(req_type);
	assign out_free = !out_valid_q || out_ready;
	assign s1_fire  = s1_valid_q && out_free;
	assign in_ready = !s1_valid_q || out_free;
	assign in_fire  = in_valid && in_ready;
	assign wr_en    = s1_fire && (req_s1 == REQ_DRAW);
	assign out_valid = out_valid_q;

	sxfb_index #(
		.DISPLAY_WIDTH (DISPLAY_WIDTH),
		.DISPLAY_HEIGHT(DISPLAY_HEIGHT)
	) u_index (
		.x_pos     (x_pos),
		.y_pos     (y_pos),
		.row_offset(row_offset),
		.row       (draw_row_idx),
		.col       (col_in)
	);

	assign rd_addr = (req_in == REQ_READ) ? AW'(read_row) : draw_row_idx;

	sxfb_ram #(
		.WIDTH(DISPLAY_WIDTH),
		.DEPTH(DISPLAY_HEIGHT)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr_s1),
		.wdata(new_row),
		.re   (in_fire),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (fwd_hit_s1) begin
			old_row = fwd_data_s1;
		end else if (row_valid_q[addr_s1]) begin
			old_row = ram_rdata;
		end else begin
			old_row = '0;
		end
	end

	sxfb_update #(
		.DISPLAY_WIDTH(DISPLAY_WIDTH)
	) u_update (
		.req      (req_s1),
		.old_row  (old_row),
		.col      (col_s1),
		.row_bits (bits_s1),
		.off_zero (off_zero_s1),
		.flags_in (flags_q),
		.new_row  (new_row),
		.flags_out(flags_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			row_valid_q <= '0;
			flags_q     <= '0;
			fwd_hit_s1  <= 1'b0;
		end else begin
			if (in_fire) begin
				s1_valid_q <= 1'b1;
				fwd_hit_s1 <= wr_en && (addr_s1 == rd_addr);
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				out_valid_q <= 1'b1;
				flags_q     <= flags_nx;
				if (req_s1 == REQ_CLEAR) begin
					row_valid_q <= '0;
				end else if (wr_en) begin
					row_valid_q[addr_s1] <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_s1      <= req_in;
			addr_s1     <= rd_addr;
			col_s1      <= col_in;
			bits_s1     <= row_bits;
			off_zero_s1 <= (row_offset == 4'd0);
			rd_ok_s1    <= (8'(read_row) < 8'(DISPLAY_HEIGHT));
			fwd_data_s1 <= new_row;
		end
		if (s1_fire) begin
			collision     <= flags_nx.collision;
			redraw_needed <= flags_nx.redraw;
			if (req_s1 == REQ_READ && rd_ok_s1) begin
				row_data <= ROW_BITS'(old_row);
			end else begin
				row_data <= '0;
			end
		end
	end

	a_clear_drops_rows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && req_s1 == REQ_CLEAR |=> row_valid_q == '0)
		else $error("rows still valid after clear");

	a_data_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && req_s1 != REQ_READ |=> row_data == '0)
		else $error("row data on non-read item");

	a_ack_clears_redraw: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && req_s1 == REQ_ACK |=> !redraw_needed && out_valid)
		else $error("acknowledge left redraw set");

	a_accept_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> s1_valid_q)
		else $error("accepted item lost");

endmodule
